FILE: src/rwl_pkg.sv
package rwl_pkg;

    localparam int DEF_REQUESTERS  = 16;
    localparam int DEF_QUEUE_DEPTH = 16;

    localparam int KIND_W   = 3;
    localparam int ID_W     = 4;
    localparam int STATUS_W = 2;
    localparam int READER_W = 5;
    localparam int RESULT_W = 5;

    localparam logic [KIND_W-1:0] KIND_READ       = 3'd0;
    localparam logic [KIND_W-1:0] KIND_QUICK_READ = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WRITE      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_READ_REL   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_WRITE_REL  = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_HOLD = 2'd2;

    localparam logic [READER_W-1:0] READERS_MAX = 5'd31;
    localparam logic [RESULT_W-1:0] MAX_RESULTS = 5'd17;

    // one waiting ticket
    typedef struct packed {
        logic            write;
        logic [ID_W-1:0] id;
    } entry_t;

    // sequencer to ticket queue
    typedef struct packed {
        logic   push;
        logic   pop;
        logic   rd;
        entry_t wr_entry;
    } qctl_t;

endpackage

FILE: src/rwl_wait_queue.sv
module rwl_wait_queue #(
    parameter int QUEUE_DEPTH = rwl_pkg::DEF_QUEUE_DEPTH,
    localparam int PTR_W = $clog2(QUEUE_DEPTH),
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rwl_pkg::qctl_t     ctrl,
    output logic [CNT_W-1:0]   count,
    output rwl_pkg::entry_t    rd_entry
);
    import rwl_pkg::*;

    localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W + 1)'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

    entry_t mem [QUEUE_DEPTH];

    logic [PTR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W:0]   tail_sum;
    logic [PTR_W-1:0] tail;
    entry_t           rd_entry_reg;

    // tail slot, head plus count folded once
    assign tail_sum = {1'b0, head_reg} + (PTR_W + 1)'(count_reg);
    assign tail     = (tail_sum >= DEPTH_EXT) ? PTR_W'(tail_sum - DEPTH_EXT)
                                              : tail_sum[PTR_W-1:0];

    always_comb
    begin
        head_next = head_reg;
        if (ctrl.pop)
        begin
            head_next = (head_reg == LAST_PTR) ? '0 : head_reg + 1'b1;
        end
    end

    always_comb
    begin
        unique case ({ctrl.push, ctrl.pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[tail] <= ctrl.wr_entry;
        end
        if (ctrl.rd)
        begin
            rd_entry_reg <= mem[head_reg];
        end
    end

    assign count    = count_reg;
    assign rd_entry = rd_entry_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("ticket count beyond depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.push |-> count_reg != FULL_CNT)
        else $error("push into full ticket queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pop |-> count_reg != '0 && !ctrl.push)
        else $error("pop from empty queue or together with push");

endmodule

FILE: src/rwl_quick_pick.sv
module rwl_quick_pick #(
    parameter int REQUESTERS = rwl_pkg::DEF_REQUESTERS,
    localparam int REQ_W = $clog2(REQUESTERS)
) (
    input  logic [REQUESTERS-1:0] waiting,
    output logic [REQUESTERS-1:0] onehot,
    output logic [REQ_W-1:0]      idx,
    output logic                  any
);
    import rwl_pkg::*;

    // lowest waiting id: isolate the lowest set bit, then encode it
    assign onehot = waiting & (~waiting + 1'b1);
    assign any    = |waiting;

    always_comb
    begin
        idx = '0;
        for (int i = 0; i < REQUESTERS; i++)
        begin
            if (onehot[i])
            begin
                idx = idx | REQ_W'(i);
            end
        end
    end

endmodule

FILE: src/fifo_rw_lock_arbiter.sv
// channel  | dir | payload                                   | handshake
// s_axis   | in  | tdata requester, tuser kind               | tvalid/tready
// m_axis   | out | tdata grantee/status, tuser flags, tlast  | tvalid/tready
//
// an event passes through accept and apply, quick scan, queue head check and
// final result. each quick-read grant is made in the quick scan, each queued
// reader granted takes a registered ticket read, then the check, and a ticket
// that ends the walk, a granted writer or a blocked head, goes to the final result
// reset is asynchronous, active low; the ticket memory needs no clearing pass
// a stalled result stalls the sequencer at its next grant or final result
module fifo_rw_lock_arbiter #(
    parameter int REQUESTERS  = rwl_pkg::DEF_REQUESTERS,
    parameter int QUEUE_DEPTH = rwl_pkg::DEF_QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [3:0] requester, [7:4] unused
    input  logic [2:0] s_axis_tuser,   // [2:0] kind
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [3:0] grantee, [5:4] status, [7:6] zero
    output logic [1:0] m_axis_tuser,   // [0] granted, [1] grant_write
    output logic       m_axis_tlast
);
    import rwl_pkg::*;

    localparam int REQ_W = $clog2(REQUESTERS);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_QUICK  = 3'd1;
    localparam logic [2:0] S_HEAD   = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [REQUESTERS-1:0] quick_reg, quick_next;
    logic [READER_W-1:0]   readers_reg, readers_next;
    logic                  writer_reg, writer_next;
    logic [RESULT_W-1:0]   n_reg, n_next;
    logic [STATUS_W-1:0]   st_reg, st_next;

    // one grant held back until we know whether another follows
    logic                  pend_valid_reg, pend_valid_next;
    logic [ID_W-1:0]       pend_id_reg, pend_id_next;
    logic                  pend_write_reg, pend_write_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic                  out_granted_reg, out_granted_next;
    logic [ID_W-1:0]       out_id_reg, out_id_next;
    logic                  out_write_reg, out_write_next;
    logic [STATUS_W-1:0]   out_st_reg, out_st_next;
    logic                  out_last_reg, out_last_next;

    logic [KIND_W-1:0]     kind;
    logic [ID_W-1:0]       req_id;
    logic [REQ_W-1:0]      req_idx;
    logic                  in_range;

    qctl_t                 qctl;
    logic [CNT_W-1:0]      q_count;
    entry_t                q_entry;

    logic [REQUESTERS-1:0] pick_onehot;
    logic [REQ_W-1:0]      pick_idx;
    logic                  pick_any;

    logic                  can_emit;
    logic                  slot_ok;
    logic                  grant_fire;
    logic [ID_W-1:0]       grant_id;
    logic                  grant_wr;

    assign kind     = s_axis_tuser;
    assign req_id   = s_axis_tdata[ID_W-1:0];
    assign req_idx  = REQ_W'(req_id);
    assign in_range = int'(req_id) < REQUESTERS;

    rwl_wait_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (qctl),
        .count    (q_count),
        .rd_entry (q_entry)
    );

    rwl_quick_pick #(
        .REQUESTERS (REQUESTERS)
    ) u_pick (
        .waiting (quick_reg),
        .onehot  (pick_onehot),
        .idx     (pick_idx),
        .any     (pick_any)
    );

    assign s_axis_tready = (state_reg == S_IDLE);

    // output register free this cycle
    assign can_emit = !out_valid_reg || m_axis_tready;
    // a new grant may be taken if the held one can move on
    assign slot_ok  = !pend_valid_reg || can_emit;

    always_comb
    begin
        state_next       = state_reg;
        quick_next       = quick_reg;
        readers_next     = readers_reg;
        writer_next      = writer_reg;
        n_next           = n_reg;
        st_next          = st_reg;
        pend_valid_next  = pend_valid_reg;
        pend_id_next     = pend_id_reg;
        pend_write_next  = pend_write_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_granted_next = out_granted_reg;
        out_id_next      = out_id_reg;
        out_write_next   = out_write_reg;
        out_st_next      = out_st_reg;
        out_last_next    = out_last_reg;
        qctl             = '0;
        grant_fire       = 1'b0;
        grant_id         = '0;
        grant_wr         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    st_next         = STATUS_OK;
                    n_next          = '0;
                    pend_valid_next = 1'b0;
                    state_next      = S_QUICK;
                    if (in_range)
                    begin
                        unique case (kind)
                            KIND_READ, KIND_WRITE:
                            begin
                                if (q_count == FULL_CNT)
                                begin
                                    st_next = STATUS_FULL;
                                end
                                else
                                begin
                                    qctl.push           = 1'b1;
                                    qctl.wr_entry.id    = req_id;
                                    qctl.wr_entry.write = (kind == KIND_WRITE);
                                end
                            end
                            KIND_QUICK_READ:
                            begin
                                quick_next = quick_reg | (REQUESTERS'(1) << req_idx);
                            end
                            KIND_READ_REL:
                            begin
                                if (readers_reg == '0)
                                begin
                                    st_next = STATUS_NO_HOLD;
                                end
                                else
                                begin
                                    readers_next = readers_reg - 1'b1;
                                end
                            end
                            KIND_WRITE_REL:
                            begin
                                if (!writer_reg)
                                begin
                                    st_next = STATUS_NO_HOLD;
                                end
                                else
                                begin
                                    writer_next = 1'b0;
                                end
                            end
                            default:
                            begin
                                st_next = STATUS_OK;
                            end
                        endcase
                    end
                end
            end

            // waiting quick readers, lowest id first
            S_QUICK:
            begin
                if (!writer_reg && pick_any && n_reg < MAX_RESULTS
                    && readers_reg < READERS_MAX)
                begin
                    if (slot_ok)
                    begin
                        grant_fire   = 1'b1;
                        grant_id     = ID_W'(pick_idx);
                        grant_wr     = 1'b0;
                        quick_next   = quick_reg & ~pick_onehot;
                        readers_next = readers_reg + 1'b1;
                    end
                end
                else
                begin
                    state_next = S_HEAD;
                end
            end

            S_HEAD:
            begin
                if (q_count != '0 && n_reg < MAX_RESULTS)
                begin
                    qctl.rd    = 1'b1;
                    state_next = S_CHECK;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            S_CHECK:
            begin
                if (q_entry.write)
                begin
                    if (readers_reg == '0 && !writer_reg)
                    begin
                        if (slot_ok)
                        begin
                            grant_fire  = 1'b1;
                            grant_id    = q_entry.id;
                            grant_wr    = 1'b1;
                            writer_next = 1'b1;
                            qctl.pop    = 1'b1;
                            state_next  = S_FINISH;
                        end
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
                else if (writer_reg || readers_reg >= READERS_MAX)
                begin
                    state_next = S_FINISH;
                end
                else if (slot_ok)
                begin
                    grant_fire   = 1'b1;
                    grant_id     = q_entry.id;
                    grant_wr     = 1'b0;
                    readers_next = readers_reg + 1'b1;
                    qctl.pop     = 1'b1;
                    state_next   = S_HEAD;
                end
            end

            S_FINISH:
            begin
                if (can_emit)
                begin
                    out_valid_next   = 1'b1;
                    out_granted_next = pend_valid_reg;
                    out_id_next      = pend_valid_reg ? pend_id_reg : '0;
                    out_write_next   = pend_valid_reg && pend_write_reg;
                    out_st_next      = st_reg;
                    out_last_next    = 1'b1;
                    pend_valid_next  = 1'b0;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a new grant pushes the held one out as a non-final result
        if (grant_fire)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next   = 1'b1;
                out_granted_next = 1'b1;
                out_id_next      = pend_id_reg;
                out_write_next   = pend_write_reg;
                out_st_next      = st_reg;
                out_last_next    = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_id_next    = grant_id;
            pend_write_next = grant_wr;
            n_next          = n_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            quick_reg      <= '0;
            readers_reg    <= '0;
            writer_reg     <= 1'b0;
            n_reg          <= '0;
            st_reg         <= STATUS_OK;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            quick_reg      <= quick_next;
            readers_reg    <= readers_next;
            writer_reg     <= writer_next;
            n_reg          <= n_next;
            st_reg         <= st_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        pend_id_reg     <= pend_id_next;
        pend_write_reg  <= pend_write_next;
        out_granted_reg <= out_granted_next;
        out_id_reg      <= out_id_next;
        out_write_reg   <= out_write_next;
        out_st_reg      <= out_st_next;
        out_last_reg    <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_st_reg, out_id_reg};
    assign m_axis_tuser  = {out_write_reg, out_granted_reg};
    assign m_axis_tlast  = out_last_reg;

    a_excl_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(writer_reg && readers_reg != '0))
        else $error("writer and readers hold the lock together");

    a_idle_flushed: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !pend_valid_reg)
        else $error("held grant left over while idle");

    a_grant_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= MAX_RESULTS)
        else $error("too many grants for one request");

endmodule
